### sv/o2srp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// o2srp_pkg
// Shared types, codes and character tables for the O2 sensor reply parser.
// ----------------------------------------------------------------------------
package o2srp_pkg;

    localparam int ECHO_LEN    = 5;
    localparam int FIELD_CHARS = 30;
    localparam int REQ_KINDS   = 5;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_CONFIRM,
        PH_TYPE,
        PH_CHANNEL,
        PH_VERSION,
        PH_SUBSENSORS,
        PH_O2,
        PH_TEMP,
        PH_STATUS,
        PH_DPHI,
        PH_INTENSITY,
        PH_AMBIENT,
        PH_PRESSURE,
        PH_HUMIDITY,
        PH_NR
    } t_phase;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_CHECK,
        CS_INFO,
        CS_ID,
        CS_O2,
        CS_RAW,
        CS_ERROR
    } t_req;

    typedef enum logic [3:0] {
        FK_NONE,
        FK_O2,
        FK_TEMP,
        FK_STATUS,
        FK_INTENSITY,
        FK_AMBIENT,
        FK_PRESSURE,
        FK_HUMIDITY,
        FK_ID,
        FK_TYPE,
        FK_CHANNEL,
        FK_VERSION,
        FK_SUBSENSORS
    } t_fkind;

    // Field being read: value, character count, digits ended by a non-digit.
    typedef struct packed {
        logic [63:0] acc;
        logic [4:0]  cnt;
        logic        stopped;
    } t_field;

    // Matcher state seen by the confirm-phase logic.
    typedef struct packed {
        logic [2:0] echo_idx;
        logic [2:0] err_idx;
        logic [2:0] armed_cmd;
        logic       armed_valid;
        t_req       req_state;
        logic       err_flag;
        logic       conn_flag;
        logic       mux_sel;
    } t_echo_st;

    // Confirm-phase outcome for one byte.
    typedef struct packed {
        logic [2:0] echo_idx;
        logic [2:0] err_idx;
        t_req       req_state;
        logic       err_flag;
        logic       conn_flag;
        logic       done;
        t_phase     phase;
    } t_echo_res;

    function automatic logic [7:0] err_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = "#";
            3'd1:    c = "E";
            3'd2:    c = "R";
            3'd3:    c = "R";
            3'd4:    c = "O";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cmd_char(input logic [2:0] cmd, input logic [2:0] idx);
        logic [39:0] txt;
        logic [7:0]  c;
        case (cmd)
            3'd0:    txt = "#LOGO";
            3'd1:    txt = "#VERS";
            3'd2:    txt = "#IDNR";
            3'd3:    txt = "#DOXY";
            3'd4:    txt = "#DRAW";
            default: txt = '0;
        endcase
        case (idx)
            3'd0:    c = txt[39:32];
            3'd1:    c = txt[31:24];
            3'd2:    c = txt[23:16];
            3'd3:    c = txt[15:8];
            3'd4:    c = txt[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### sv/o2srp_echo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// o2srp_echo
// Confirm phase: track the command echo and the error reply for one byte.
// ----------------------------------------------------------------------------
module o2srp_echo (
    input  wire logic [7:0]          i_byte,
    input  wire o2srp_pkg::t_echo_st i_st,
    output o2srp_pkg::t_echo_res     o_res
);

    logic       match;
    logic [2:0] ei;
    logic [2:0] xi;

    always_comb begin
        o_res.req_state = i_st.req_state;
        o_res.err_flag  = i_st.err_flag;
        o_res.conn_flag = i_st.conn_flag;
        o_res.done      = 1'b0;
        o_res.phase     = o2srp_pkg::PH_CONFIRM;
        ei = i_st.echo_idx;
        xi = i_st.err_idx;

        // a hash restarts both matches
        if (i_byte == o2srp_pkg::CHAR_HASH) begin
            ei = '0;
            xi = '0;
        end

        if (xi < 3'(o2srp_pkg::ECHO_LEN)) begin
            if (i_byte == o2srp_pkg::err_char(xi)) begin
                xi = xi + 3'd1;
            end else begin
                xi = '0;
            end
        end else begin
            // byte after a full error reply
            o_res.err_flag = 1'b1;
            xi = '0;
            if (o_res.req_state != o2srp_pkg::CS_IDLE) begin
                o_res.req_state = o2srp_pkg::CS_ERROR;
            end
        end

        match = i_st.armed_valid && (ei < 3'(o2srp_pkg::ECHO_LEN)) &&
                (i_byte == o2srp_pkg::cmd_char(i_st.armed_cmd, ei));

        if (match) begin
            ei = ei + 3'd1;
            if (ei == 3'(o2srp_pkg::ECHO_LEN)) begin
                o_res.done = 1'b1;
                xi = '0;
                ei = '0;
                o_res.conn_flag = i_st.mux_sel ? ~o_res.err_flag : 1'b1;
                case (o_res.req_state)
                    o2srp_pkg::CS_ID:   o_res.phase = o2srp_pkg::PH_NR;
                    o2srp_pkg::CS_INFO: o_res.phase = o2srp_pkg::PH_TYPE;
                    o2srp_pkg::CS_O2,
                    o2srp_pkg::CS_RAW:  o_res.phase = o2srp_pkg::PH_O2;
                    default: begin
                        o_res.req_state = o2srp_pkg::CS_IDLE;
                        o_res.phase     = o2srp_pkg::PH_IDLE;
                    end
                endcase
            end
        end else begin
            ei = '0;
        end

        o_res.echo_idx = ei;
        o_res.err_idx  = xi;
    end

endmodule
`default_nettype wire

### sv/o2srp_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// o2srp_accum
// Add one character to the current field: decimal multiply-accumulate with
// saturation at all ones.
// ----------------------------------------------------------------------------
module o2srp_accum (
    input  wire logic [7:0]        i_byte,
    input  wire o2srp_pkg::t_field i_field,
    output o2srp_pkg::t_field      o_field
);

    logic        is_digit;
    logic [7:0]  digit;
    logic [67:0] wide;

    assign is_digit = (i_byte >= o2srp_pkg::CHAR_ZERO) && (i_byte <= o2srp_pkg::CHAR_NINE);
    assign digit    = i_byte - o2srp_pkg::CHAR_ZERO;
    // acc * 10 + d as (acc << 3) + (acc << 1) + d
    assign wide     = ({4'b0, i_field.acc} << 3) + ({4'b0, i_field.acc} << 1) +
                      {64'b0, digit[3:0]};

    always_comb begin
        o_field = i_field;
        if (i_field.cnt < 5'(o2srp_pkg::FIELD_CHARS)) begin
            o_field.cnt = i_field.cnt + 5'd1;
            if (!i_field.stopped) begin
                if (is_digit) begin
                    o_field.acc = (wide[67:64] != 4'b0) ? '1 : wide[63:0];
                end else begin
                    o_field.stopped = 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

### sv/o2_sensor_response_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// o2_sensor_response_parser
// Byte-wise parser for an O2 sensor's ASCII reply: echo and error detection,
// then space-separated decimal fields reported with their kind.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Signals                          Payload
// -------   ---------  -------------------------------  -------------------------------
// s_axis    in         tvalid tready tdata[15:0] tuser  begin request or received byte
// m_axis    out        tvalid tready tdata[71:0] tuser  field result, tlast = record done
//                      tlast
// cfg       in         i_cfg_valid o_cfg_ready          mux_selected
//                      i_cfg_data
//
// Each transfer passes an input register, the parse logic and a result
// register; one item is taken per cycle unless the pipe holds as below.
// The parse step is a small decision plus a 68-bit multiply-by-ten add.
// When the result register is full and m_axis_tready is low, the pipe holds
// and s_axis_tready drops in the same cycle once the input register is full.
// Reset (synchronous, active low) clears the parse state, flags and the
// valid bits of both registers; the config port is always ready.
// ----------------------------------------------------------------------------
module o2_sensor_response_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] request_kind, [3] clear_flags, [11:4] rx_byte, [15:12] zero
    input  wire logic [15:0] s_axis_tdata,
    // [0] op
    input  wire logic        s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [63:0] field_value, [66:64] com_state, [67] connected, [68] error_seen,
    // [71:69] zero
    output logic [71:0]      m_axis_tdata,
    // [0] field_valid, [4:1] field_kind
    output logic [4:0]       m_axis_tuser,
    // record_done
    output logic             m_axis_tlast,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data
);

    // input register
    logic       r_in_valid;
    logic       r_in_op;
    logic [2:0] r_in_kind;
    logic       r_in_clr;
    logic [7:0] r_in_byte;

    // parse state
    logic              r_mux_sel;
    o2srp_pkg::t_phase r_phase,     n_phase;
    o2srp_pkg::t_req   r_req,       n_req;
    logic [2:0]        r_echo_idx,  n_echo_idx;
    logic [2:0]        r_err_idx,   n_err_idx;
    logic              r_err_flag,  n_err_flag;
    logic              r_conn_flag, n_conn_flag;
    logic [2:0]        r_armed_cmd, n_armed_cmd;
    logic              r_armed_vld, n_armed_vld;
    o2srp_pkg::t_field r_field,     n_field;

    // result register
    logic              r_out_valid;
    logic              r_out_fvalid, n_fvalid;
    o2srp_pkg::t_fkind r_out_fkind,  n_fkind;
    logic [63:0]       r_out_fvalue, n_fvalue;
    logic              r_out_rdone,  n_rdone;
    o2srp_pkg::t_req   r_out_req;
    logic              r_out_conn;
    logic              r_out_err;

    logic                advance;
    o2srp_pkg::t_echo_st echo_st;
    o2srp_pkg::t_echo_res echo_res;
    o2srp_pkg::t_field   field_add;
    o2srp_pkg::t_field   field_clr;

    // advance the pipe when the result register is free or being drained
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    assign field_clr = '0;

    assign echo_st = '{
        echo_idx:    r_echo_idx,
        err_idx:     r_err_idx,
        armed_cmd:   r_armed_cmd,
        armed_valid: r_armed_vld,
        req_state:   r_req,
        err_flag:    r_err_flag,
        conn_flag:   r_conn_flag,
        mux_sel:     r_mux_sel
    };

    o2srp_echo u_echo (
        .i_byte (r_in_byte),
        .i_st   (echo_st),
        .o_res  (echo_res)
    );

    o2srp_accum u_accum (
        .i_byte  (r_in_byte),
        .i_field (r_field),
        .o_field (field_add)
    );

    // one parse step for the item in the input register
    always_comb begin
        n_phase     = r_phase;
        n_req       = r_req;
        n_echo_idx  = r_echo_idx;
        n_err_idx   = r_err_idx;
        n_err_flag  = r_err_flag;
        n_conn_flag = r_conn_flag;
        n_armed_cmd = r_armed_cmd;
        n_armed_vld = r_armed_vld;
        n_field     = r_field;
        n_fkind     = o2srp_pkg::FK_NONE;
        n_rdone     = 1'b0;

        if (r_in_op == o2srp_pkg::OP_BEGIN) begin
            // arm a new request; match positions stay as they are
            n_phase = o2srp_pkg::PH_CONFIRM;
            if (r_in_kind < 3'(o2srp_pkg::REQ_KINDS)) begin
                n_armed_cmd = r_in_kind;
                n_armed_vld = 1'b1;
                n_req       = o2srp_pkg::t_req'(r_in_kind + 3'd1);
            end else begin
                n_armed_vld = 1'b0;
                n_req       = o2srp_pkg::CS_IDLE;
            end
            if (r_in_clr) begin
                n_err_flag  = 1'b0;
                n_conn_flag = 1'b0;
            end
        end else begin
            case (r_phase)
                o2srp_pkg::PH_IDLE: begin
                    n_phase = o2srp_pkg::PH_IDLE;
                end
                o2srp_pkg::PH_CONFIRM: begin
                    n_echo_idx  = echo_res.echo_idx;
                    n_err_idx   = echo_res.err_idx;
                    n_req       = echo_res.req_state;
                    n_err_flag  = echo_res.err_flag;
                    n_conn_flag = echo_res.conn_flag;
                    n_phase     = echo_res.phase;
                    if (echo_res.done) begin
                        n_field = field_clr;
                    end
                end
                default: begin
                    if (r_in_byte != o2srp_pkg::CHAR_CR) begin
                        if (r_in_byte != o2srp_pkg::CHAR_SPACE) begin
                            n_field = field_add;
                        end else if (r_field.cnt != 5'd0) begin
                            // space closes a non-empty field
                            case (r_phase)
                                o2srp_pkg::PH_TYPE: begin
                                    n_fkind = o2srp_pkg::FK_TYPE;
                                    n_phase = o2srp_pkg::PH_CHANNEL;
                                end
                                o2srp_pkg::PH_CHANNEL: begin
                                    n_fkind = o2srp_pkg::FK_CHANNEL;
                                    n_phase = o2srp_pkg::PH_VERSION;
                                end
                                o2srp_pkg::PH_VERSION: begin
                                    n_fkind = o2srp_pkg::FK_VERSION;
                                    n_phase = o2srp_pkg::PH_SUBSENSORS;
                                end
                                o2srp_pkg::PH_O2: begin
                                    n_fkind = o2srp_pkg::FK_O2;
                                    n_phase = o2srp_pkg::PH_TEMP;
                                end
                                o2srp_pkg::PH_TEMP: begin
                                    n_fkind = o2srp_pkg::FK_TEMP;
                                    n_phase = o2srp_pkg::PH_STATUS;
                                end
                                o2srp_pkg::PH_STATUS: begin
                                    n_fkind = o2srp_pkg::FK_STATUS;
                                    n_phase = o2srp_pkg::PH_DPHI;
                                end
                                o2srp_pkg::PH_DPHI: begin
                                    // drop dphi
                                    n_phase = o2srp_pkg::PH_INTENSITY;
                                end
                                o2srp_pkg::PH_INTENSITY: begin
                                    n_fkind = o2srp_pkg::FK_INTENSITY;
                                    n_phase = o2srp_pkg::PH_AMBIENT;
                                end
                                o2srp_pkg::PH_AMBIENT: begin
                                    n_fkind = o2srp_pkg::FK_AMBIENT;
                                    n_phase = o2srp_pkg::PH_PRESSURE;
                                end
                                o2srp_pkg::PH_PRESSURE: begin
                                    n_fkind = o2srp_pkg::FK_PRESSURE;
                                    n_phase = o2srp_pkg::PH_HUMIDITY;
                                end
                                default: begin
                                    n_phase = r_phase;
                                end
                            endcase
                            n_field = field_clr;
                        end
                    end else begin
                        // CR ends the reply
                        case (r_phase)
                            o2srp_pkg::PH_STATUS: begin
                                n_fkind = o2srp_pkg::FK_STATUS;
                                n_rdone = 1'b1;
                            end
                            o2srp_pkg::PH_SUBSENSORS: begin
                                n_fkind = o2srp_pkg::FK_SUBSENSORS;
                            end
                            o2srp_pkg::PH_HUMIDITY: begin
                                n_fkind = o2srp_pkg::FK_HUMIDITY;
                                n_rdone = 1'b1;
                            end
                            o2srp_pkg::PH_NR: begin
                                n_fkind = o2srp_pkg::FK_ID;
                                n_rdone = 1'b1;
                            end
                            default: begin
                                n_fkind = o2srp_pkg::FK_NONE;
                            end
                        endcase
                        n_req   = o2srp_pkg::CS_IDLE;
                        n_phase = o2srp_pkg::PH_IDLE;
                        n_field = field_clr;
                    end
                end
            endcase
        end

        n_fvalid = (n_fkind != o2srp_pkg::FK_NONE);
        n_fvalue = n_fvalid ? r_field.acc : 64'd0;
    end

    // control and parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mux_sel   <= 1'b0;
            r_phase     <= o2srp_pkg::PH_IDLE;
            r_req       <= o2srp_pkg::CS_IDLE;
            r_echo_idx  <= '0;
            r_err_idx   <= '0;
            r_err_flag  <= 1'b0;
            r_conn_flag <= 1'b0;
            r_armed_cmd <= '0;
            r_armed_vld <= 1'b0;
            r_field     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_mux_sel <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_phase     <= n_phase;
                r_req       <= n_req;
                r_echo_idx  <= n_echo_idx;
                r_err_idx   <= n_err_idx;
                r_err_flag  <= n_err_flag;
                r_conn_flag <= n_conn_flag;
                r_armed_cmd <= n_armed_cmd;
                r_armed_vld <= n_armed_vld;
                r_field     <= n_field;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_kind <= s_axis_tdata[2:0];
            r_in_clr  <= s_axis_tdata[3];
            r_in_byte <= s_axis_tdata[11:4];
        end
        if (advance) begin
            r_out_fvalid <= n_fvalid;
            r_out_fkind  <= n_fkind;
            r_out_fvalue <= n_fvalue;
            r_out_rdone  <= n_rdone;
            r_out_req    <= n_req;
            r_out_conn   <= n_conn_flag;
            r_out_err    <= n_err_flag;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b0, r_out_err, r_out_conn, r_out_req, r_out_fvalue};
    assign m_axis_tuser  = {r_out_fkind, r_out_fvalid};
    assign m_axis_tlast  = r_out_rdone;

endmodule
`default_nettype wire
